FILE: src/erfl_pkg.sv
// Shared widths, register indexes, divider operation codes and control structs.
package erfl_pkg;

   localparam int TICKS_W   = 16;
   localparam int CFG_W     = 10;
   localparam int SUM_W     = 13;
   localparam int CNT_W     = 3;
   localparam int FILL_W    = 7;
   localparam int PCT_W     = 7;
   localparam int DIV_N_W   = 17;
   localparam int DIV_CNT_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_CM    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE_CM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE_CM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_DEPTH_CM    = 2'd3;

   localparam logic [CFG_W-1:0] TICKS_PER_CM_RESET    = 10'd56;
   localparam logic [CFG_W-1:0] MIN_DISTANCE_CM_RESET = 10'd2;
   localparam logic [CFG_W-1:0] MAX_DISTANCE_CM_RESET = 10'd450;
   localparam logic [CFG_W-1:0] BIN_DEPTH_CM_RESET    = 10'd65;

   localparam logic [PCT_W-1:0]     PERCENT_SCALE = 7'd100;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS     = 5'd17;

   localparam logic [1:0] DIV_OP_DIST = 2'd0;
   localparam logic [1:0] DIV_OP_AVG  = 2'd1;
   localparam logic [1:0] DIV_OP_FILL = 2'd2;

   typedef struct packed {
      logic       load_req;
      logic       div_start;
      logic [1:0] div_op;
      logic       evaluate;
      logic       scale;
      logic       store_fill;
      logic       load_rsp;
   } erfl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic set_done;
      logic rsp_free;
   } erfl_status_type;

endpackage

FILE: src/erfl_req_if.sv
// Input channel carrying one echo measurement per transaction.
interface erfl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] echo_ticks;
   logic        sensor_select;

   modport source (output valid, output echo_ticks, output sensor_select, input ready);
   modport sink   (input valid, input echo_ticks, input sensor_select, output ready);
endinterface

FILE: src/erfl_rsp_if.sv
// Result channel carrying one distance and fill report per transaction.
interface erfl_rsp_if;
   logic       valid;
   logic       ready;
   logic       reading_valid;
   logic       sensor_id;
   logic [15:0] distance_cm;
   logic       result_ready;
   logic [9:0] average_cm;
   logic [6:0] fill_percent;

   modport source (output valid, output reading_valid, output sensor_id, output distance_cm,
                   output result_ready, output average_cm, output fill_percent, input ready);
   modport sink   (input valid, input reading_valid, input sensor_id, input distance_cm,
                   input result_ready, input average_cm, input fill_percent, output ready);
endinterface

FILE: src/erfl_ctrl.sv
// Controller state machine sequencing the shared divider for each measurement.
module erfl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  erfl_pkg::erfl_status_type status,
   output erfl_pkg::erfl_cmd_type    cmd
);
   import erfl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIST  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_AVG   = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_FILL  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_op = DIV_OP_DIST;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OP_DIST;
               state_in      = S_DIST;
            end
         end
         S_DIST: begin
            if (!status.div_busy) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.evaluate = 1'b1;
            if (status.set_done) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIV_OP_AVG;
               state_in      = S_AVG;
            end else begin
               state_in = S_OUT;
            end
         end
         S_AVG: begin
            if (!status.div_busy) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale     = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_OP_FILL;
            state_in      = S_FILL;
         end
         S_FILL: begin
            if (!status.div_busy) begin
               cmd.store_fill = 1'b1;
               state_in       = S_OUT;
            end
         end
         S_OUT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/erfl_dp.sv
// Datapath: configuration registers, accumulator, shared restoring divider and result register.
module erfl_dp #(
   parameter int READINGS_PER_RESULT = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  erfl_pkg::erfl_cmd_type              cmd,
   output erfl_pkg::erfl_status_type           status,
   input  logic [erfl_pkg::TICKS_W-1:0]        req_echo_ticks,
   input  logic                                req_sensor_select,
   input  logic                                csr_write_enable,
   input  logic [erfl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [erfl_pkg::CFG_W-1:0]          csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_reading_valid,
   output logic                                rsp_sensor_id,
   output logic [erfl_pkg::TICKS_W-1:0]        rsp_distance_cm,
   output logic                                rsp_result_ready,
   output logic [erfl_pkg::CFG_W-1:0]          rsp_average_cm,
   output logic [erfl_pkg::FILL_W-1:0]         rsp_fill_percent
);
   import erfl_pkg::*;

   localparam logic [CFG_W-1:0] SET_DIVISOR = CFG_W'(READINGS_PER_RESULT);
   localparam logic [CNT_W-1:0] SET_SIZE    = CNT_W'(READINGS_PER_RESULT);

   logic [CFG_W-1:0]     ticks_per_cm_ff, min_dist_ff, max_dist_ff, depth_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 sensor_ff;

   logic [CFG_W-1:0]     div_rem_ff, div_rem_in;
   logic [DIV_N_W-1:0]   div_quo_ff, div_quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CFG_W-1:0]     divisor_ff, divisor_in;
   logic [DIV_N_W-1:0]   dividend;
   logic [CFG_W:0]       trial;
   logic [CFG_W:0]       trial_diff;
   logic                 trial_ge;

   logic                 res_valid_ff;
   logic [TICKS_W-1:0]   res_dist_ff;
   logic                 res_ready_ff;
   logic [CFG_W-1:0]     res_avg_ff;
   logic [FILL_W-1:0]    res_fill_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_reading_valid_ff, rsp_sensor_id_ff, rsp_result_ready_ff;
   logic [TICKS_W-1:0]   rsp_distance_cm_ff;
   logic [CFG_W-1:0]     rsp_average_cm_ff;
   logic [FILL_W-1:0]    rsp_fill_percent_ff;

   logic [TICKS_W-1:0]   dist_cm;
   logic                 in_window;
   logic [SUM_W-1:0]     sum_add;
   logic [CNT_W-1:0]     count_add;
   logic                 set_done;
   logic [SUM_W-1:0]     avg_raw;
   logic [CFG_W-1:0]     avg_clamped;
   logic [CFG_W-1:0]     depth_left;
   logic [DIV_N_W-1:0]   scaled;

   // Reading evaluation from the finished distance quotient.
   assign dist_cm   = div_quo_ff[TICKS_W-1:0];
   assign in_window = (dist_cm > {6'd0, min_dist_ff}) && (dist_cm <= {6'd0, max_dist_ff});
   assign sum_add   = sum_ff + dist_cm[SUM_W-1:0];
   assign count_add = count_ff + 3'd1;
   assign set_done  = in_window && (count_add >= SET_SIZE);

   // Average clamp and percent scaling.
   assign avg_raw     = div_quo_ff[SUM_W-1:0];
   assign avg_clamped = (avg_raw > {3'd0, depth_ff}) ? depth_ff : avg_raw[CFG_W-1:0];
   assign depth_left  = depth_ff - avg_clamped;
   assign scaled      = {7'd0, depth_left} * {10'd0, PERCENT_SCALE};

   always_comb begin
      case (cmd.div_op)
         DIV_OP_DIST: begin
            dividend   = {1'b0, req_echo_ticks};
            divisor_in = ticks_per_cm_ff;
         end
         DIV_OP_AVG: begin
            dividend   = {4'd0, sum_add};
            divisor_in = SET_DIVISOR;
         end
         default: begin
            dividend   = scaled;
            divisor_in = depth_ff;
         end
      endcase
   end

   // One quotient bit per cycle; a zero divisor yields all ones.
   assign trial      = {div_rem_ff, div_quo_ff[DIV_N_W-1]};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_start) begin
         div_rem_in = '0;
         div_quo_in = dividend;
         div_cnt_in = DIV_STEPS;
      end else if (div_cnt_ff != '0) begin
         div_rem_in = trial_ge ? trial_diff[CFG_W-1:0] : trial[CFG_W-1:0];
         div_quo_in = {div_quo_ff[DIV_N_W-2:0], trial_ge};
         div_cnt_in = div_cnt_ff - 5'd1;
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.evaluate && in_window) begin
         if (set_done) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_add;
            count_in = count_add;
         end
      end
   end

   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_cm_ff <= TICKS_PER_CM_RESET;
         min_dist_ff     <= MIN_DISTANCE_CM_RESET;
         max_dist_ff     <= MAX_DISTANCE_CM_RESET;
         depth_ff        <= BIN_DEPTH_CM_RESET;
         sum_ff          <= '0;
         count_ff        <= '0;
         div_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TICKS_PER_CM:    ticks_per_cm_ff <= csr_write_data;
               CSR_MIN_DISTANCE_CM: min_dist_ff     <= csr_write_data;
               CSR_MAX_DISTANCE_CM: max_dist_ff     <= csr_write_data;
               CSR_BIN_DEPTH_CM:    depth_ff        <= csr_write_data;
               default: begin
               end
            endcase
         end
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      if (cmd.div_start) begin
         divisor_ff <= divisor_in;
      end
      if (cmd.load_req) begin
         sensor_ff <= req_sensor_select;
      end
      if (cmd.evaluate) begin
         res_valid_ff <= in_window;
         res_dist_ff  <= dist_cm;
         res_ready_ff <= set_done;
         res_avg_ff   <= '0;
         res_fill_ff  <= '0;
      end
      if (cmd.scale) begin
         res_avg_ff <= avg_clamped;
      end
      if (cmd.store_fill) begin
         res_fill_ff <= (depth_ff == '0) ? '0 : div_quo_ff[FILL_W-1:0];
      end
      if (cmd.load_rsp) begin
         rsp_reading_valid_ff <= res_valid_ff;
         rsp_sensor_id_ff     <= sensor_ff;
         rsp_distance_cm_ff   <= res_dist_ff;
         rsp_result_ready_ff  <= res_ready_ff;
         rsp_average_cm_ff    <= res_avg_ff;
         rsp_fill_percent_ff  <= res_fill_ff;
      end
   end

   assign status.div_busy = (div_cnt_ff != '0);
   assign status.set_done = set_done;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reading_valid = rsp_reading_valid_ff;
   assign rsp_sensor_id     = rsp_sensor_id_ff;
   assign rsp_distance_cm   = rsp_distance_cm_ff;
   assign rsp_result_ready  = rsp_result_ready_ff;
   assign rsp_average_cm    = rsp_average_cm_ff;
   assign rsp_fill_percent  = rsp_fill_percent_ff;

endmodule

FILE: src/echo_ranging_fill_level_unit.sv
// Top level of the echo ranging fill level unit: controller plus datapath.
//
// Each req_chan transaction carries one finished echo measurement (timer
// ticks and sensor). Each one yields exactly one rsp_chan transaction with
// the distance in centimeters, whether it lay inside the valid window, and,
// on every sixth valid reading, the clamped average and the fill percent.
// One restoring divider (17 quotient bits, one bit per cycle) is shared by
// the distance, average and percent divisions. A reading that does not
// complete a set runs the divider once, for its distance; one that
// completes a set runs it three times, for distance, average and percent.
// The unit works on one measurement at a time; req_chan.ready is high only
// while it is waiting for one. The next measurement can be accepted in the
// cycle after a result is loaded. The finished transaction sits in an
// output register, so a new measurement is accepted while rsp_chan is
// stalled; its result waits until the output register is taken.
// The user must write configuration through csr_write_enable, csr_index
// and csr_write_data only while the unit is idle; the unit itself does not
// enforce this. Synchronous reset restores the default register values
// and clears the running sum and reading count.
module echo_ranging_fill_level_unit #(
   parameter int READINGS_PER_RESULT = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   erfl_req_if.sink                       req_chan,
   erfl_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [erfl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [erfl_pkg::CFG_W-1:0]     csr_write_data
);
   import erfl_pkg::*;

   erfl_cmd_type    cmd;
   erfl_status_type status;

   erfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   erfl_dp #(
      .READINGS_PER_RESULT (READINGS_PER_RESULT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_echo_ticks    (req_chan.echo_ticks),
      .req_sensor_select (req_chan.sensor_select),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_reading_valid (rsp_chan.reading_valid),
      .rsp_sensor_id     (rsp_chan.sensor_id),
      .rsp_distance_cm   (rsp_chan.distance_cm),
      .rsp_result_ready  (rsp_chan.result_ready),
      .rsp_average_cm    (rsp_chan.average_cm),
      .rsp_fill_percent  (rsp_chan.fill_percent)
   );

endmodule
